### src/bphp_pkg.sv
// Shared constants, register indexes and types for the banded PID heater PWM block.
// Used by every module under src; no dependencies of its own.
package bphp_pkg;

   // default parameter values
   localparam int ERROR_FRAC_BITS_DEF = 10;
   localparam int SUM_WIDTH_DEF       = 32;

   // port and register widths
   localparam int TEMP_W      = 16;
   localparam int SP_W        = 12;
   localparam int GAIN_W      = 16;
   localparam int DUTY_W      = 8;
   localparam int OT_W        = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   // register reset values
   localparam logic [SP_W-1:0]   SP_RST  = 12'd0;
   localparam logic              EN_RST  = 1'b0;
   localparam logic [GAIN_W-1:0] KP_RST  = 16'd900;
   localparam logic [GAIN_W-1:0] KI_RST  = 16'd20;
   localparam logic [GAIN_W-1:0] KD_RST  = 16'd2;
   localparam logic [DUTY_W-1:0] LIM_RST = 8'd100;
   localparam logic [OT_W-1:0]   OT_RST  = 8'd80;

   // error scaling: setpoint*2^14 - temperature*2^6 has 16 fractional bits
   localparam int SP_SHIFT = 14;
   localparam int T_SHIFT  = 6;
   localparam int RAW_FRAC = 16;
   localparam int DIFF_W   = SP_W + SP_SHIFT + 1;
   localparam int OT_SHIFT = 4;

   // band edges in units of one
   localparam int BAND_LO = -2;
   localparam int BAND_HI = 4;

   // duty = n / (20 * 2^F): shift by F, then divide by 4 and by 5
   localparam int DUTY_DIVISOR   = 20;
   localparam int DUTY_RAW_CLAMP = DUTY_DIVISOR << DUTY_W;
   localparam int CLAMP_W        = $clog2(DUTY_RAW_CLAMP);
   localparam int DIV_PRE_SHIFT  = 2;
   localparam int DIV5_RECIP     = 3277;
   localparam int DIV5_SHIFT     = 14;
   localparam int RECIP_W        = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SET_POINT     = 3'd0,
      CSR_HEATER_ENABLE = 3'd1,
      CSR_PROP_GAIN     = 3'd2,
      CSR_INT_GAIN      = 3'd3,
      CSR_DERIV_GAIN    = 3'd4,
      CSR_DUTY_LIMIT    = 3'd5,
      CSR_OVER_TEMP     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic settled;
      logic force_zero;
   } bphp_ctl_type;

endpackage

### src/bphp_loop.sv
// Error calculation and loop state (error sum, last error, settled flag).
// Registers one word of error terms per load and advances loop state per step; depends on bphp_pkg.
module bphp_loop import bphp_pkg::*; #(
   parameter int ERROR_FRAC_BITS = ERROR_FRAC_BITS_DEF,
   parameter int SUM_WIDTH       = SUM_WIDTH_DEF,
   localparam int EW = DIFF_W - (RAW_FRAC - ERROR_FRAC_BITS),
   localparam int DW = EW + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        step,
   input  logic [TEMP_W-1:0]           temperature,
   input  logic [SP_W-1:0]             set_point,
   input  logic                        heater_enable,
   input  logic [OT_W-1:0]             over_temp_limit,
   output logic signed [EW-1:0]        err_ff,
   output logic signed [SUM_WIDTH-1:0] sum_term_ff,
   output logic signed [DW-1:0]        diff_term_ff,
   output bphp_ctl_type                ctl_ff
);

   localparam int SHIFT = RAW_FRAC - ERROR_FRAC_BITS;
   localparam int XW    = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
   localparam logic signed [EW-1:0] BAND_LO_E = EW'(BAND_LO * (2 ** ERROR_FRAC_BITS));
   localparam logic signed [EW-1:0] BAND_HI_E = EW'(BAND_HI * (2 ** ERROR_FRAC_BITS));
   localparam logic signed [XW-1:0] SUM_MAX_X = XW'({1'b0, {(SUM_WIDTH-1){1'b1}}});
   localparam logic signed [XW-1:0] SUM_MIN_X = ~SUM_MAX_X;

   logic signed [SUM_WIDTH-1:0] acc_ff, acc_in;
   logic signed [EW-1:0]        prev_ff;
   logic                        settled_ff, settled_in;

   logic signed [DIFF_W-1:0]    diff;
   logic signed [EW-1:0]        err;
   logic                        in_band;
   logic signed [XW-1:0]        sum_x;
   logic signed [DW-1:0]        err_diff;
   logic                        force_zero;

   assign diff = $signed(DIFF_W'({set_point, {SP_SHIFT{1'b0}}}))
               - $signed(DIFF_W'({temperature, {T_SHIFT{1'b0}}}));
   // arithmetic shift rounds toward minus infinity
   assign err     = EW'(diff >>> SHIFT);
   assign in_band = (err > BAND_LO_E) && (err < BAND_HI_E);

   assign sum_x    = XW'(acc_ff) + XW'(err);
   assign err_diff = DW'(err) - DW'(prev_ff);

   always_comb begin
      priority if (sum_x > SUM_MAX_X) begin
         acc_in = SUM_WIDTH'(SUM_MAX_X);
      end else if (sum_x < SUM_MIN_X) begin
         acc_in = SUM_WIDTH'(SUM_MIN_X);
      end else begin
         acc_in = SUM_WIDTH'(sum_x);
      end
   end

   // out of band the flag drops only below the target
   always_comb begin
      priority if (in_band) begin
         settled_in = 1'b1;
      end else if (!err[EW-1] && (err != '0)) begin
         settled_in = 1'b0;
      end else begin
         settled_in = settled_ff;
      end
   end

   assign force_zero = (temperature > TEMP_W'({over_temp_limit, {OT_SHIFT{1'b0}}}))
                     || !heater_enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         prev_ff    <= '0;
         settled_ff <= 1'b0;
      end else if (step) begin
         acc_ff     <= in_band ? acc_in : '0;
         prev_ff    <= in_band ? err : '0;
         settled_ff <= settled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff       <= err;
         sum_term_ff  <= in_band ? acc_in : '0;
         diff_term_ff <= in_band ? err_diff : '0;
         ctl_ff       <= '{settled: settled_in, force_zero: force_zero};
      end
   end

endmodule

### src/bphp_duty.sv
// Scales the PID sum to an integer duty, clamps it and applies the force-zero cases.
// Combinational; depends on bphp_pkg.
module bphp_duty import bphp_pkg::*; #(
   parameter int ERROR_FRAC_BITS = ERROR_FRAC_BITS_DEF,
   parameter int N_WIDTH         = 64
) (
   input  logic signed [N_WIDTH-1:0] pid_sum,
   input  bphp_ctl_type              ctl,
   input  logic [DUTY_W-1:0]         duty_limit,
   output logic [DUTY_W-1:0]         duty
);

   localparam int MW     = N_WIDTH - ERROR_FRAC_BITS;
   localparam int XW     = CLAMP_W - DIV_PRE_SHIFT;
   localparam int PROD_W = XW + RECIP_W;

   logic [MW-1:0]     whole;
   logic              over;
   logic [XW-1:0]     quarter;
   logic [PROD_W-1:0] prod;
   logic [DUTY_W-1:0] quot;

   assign whole   = pid_sum[N_WIDTH-1:ERROR_FRAC_BITS];
   assign over    = whole >= MW'(DUTY_RAW_CLAMP);
   // below the clamp point: divide by 4, then by 5 through a reciprocal
   assign quarter = whole[CLAMP_W-1:DIV_PRE_SHIFT];
   assign prod    = PROD_W'(quarter) * PROD_W'(DIV5_RECIP);
   assign quot    = prod[DIV5_SHIFT +: DUTY_W];

   always_comb begin
      priority if (pid_sum[N_WIDTH-1] || ctl.force_zero) begin
         duty = '0;
      end else if (over || (quot > duty_limit)) begin
         duty = duty_limit;
      end else begin
         duty = quot;
      end
   end

endmodule

### src/banded_pid_heater_pwm.sv
// Top level of the banded PID heater PWM block: registers, pipeline control, PID products.
// Depends on bphp_pkg, bphp_loop and bphp_duty.
//
// One temperature word in gives one duty word out. The block takes a word every cycle
// while req_stall is low and passes it through these stages in order: input register,
// error and loop-state stage, PID product stage, duty clamp in the output register. Each
// stage holds its word while the next one is full, so bubbles close up under a stalled
// output. Loop state (error sum, last error, settled flag) advances as a word leaves
// the input register. Write the control registers only while no word is in flight.
module banded_pid_heater_pwm import bphp_pkg::*; #(
   parameter int ERROR_FRAC_BITS = ERROR_FRAC_BITS_DEF,
   parameter int SUM_WIDTH       = SUM_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TEMP_W-1:0]      req_temperature,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DUTY_W-1:0]      rsp_duty,
   output logic                   rsp_settled,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int EW = DIFF_W - (RAW_FRAC - ERROR_FRAC_BITS);
   localparam int DW = EW + 1;
   localparam int NW = ((SUM_WIDTH > DW) ? SUM_WIDTH : DW) + GAIN_W + 3;

   // control registers
   logic [SP_W-1:0]   set_point_ff;
   logic              heater_enable_ff;
   logic [GAIN_W-1:0] prop_gain_ff, int_gain_ff, deriv_gain_ff;
   logic [DUTY_W-1:0] duty_limit_ff;
   logic [OT_W-1:0]   over_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_point_ff     <= SP_RST;
         heater_enable_ff <= EN_RST;
         prop_gain_ff     <= KP_RST;
         int_gain_ff      <= KI_RST;
         deriv_gain_ff    <= KD_RST;
         duty_limit_ff    <= LIM_RST;
         over_temp_ff     <= OT_RST;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SET_POINT:     set_point_ff     <= csr_wdata[SP_W-1:0];
            CSR_HEATER_ENABLE: heater_enable_ff <= csr_wdata[0];
            CSR_PROP_GAIN:     prop_gain_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_INT_GAIN:      int_gain_ff      <= csr_wdata[GAIN_W-1:0];
            CSR_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_DUTY_LIMIT:    duty_limit_ff    <= csr_wdata[DUTY_W-1:0];
            CSR_OVER_TEMP:     over_temp_ff     <= csr_wdata[OT_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline occupancy: a stage may load when empty or when it moves on
   logic in_valid_ff, err_valid_ff, pid_valid_ff, rsp_valid_ff;
   logic free_rsp, free_pid, free_err, free_in;

   assign free_rsp = !rsp_valid_ff || !rsp_stall;
   assign free_pid = !pid_valid_ff || free_rsp;
   assign free_err = !err_valid_ff || free_pid;
   assign free_in  = !in_valid_ff || free_err;

   assign req_stall = !free_in;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         err_valid_ff <= 1'b0;
         pid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (free_in)  in_valid_ff  <= req_valid;
         if (free_err) err_valid_ff <= in_valid_ff;
         if (free_pid) pid_valid_ff <= err_valid_ff;
         if (free_rsp) rsp_valid_ff <= pid_valid_ff;
      end
   end

   // input register
   logic [TEMP_W-1:0] temp_ff;

   always_ff @(posedge clock) begin
      if (free_in) begin
         temp_ff <= req_temperature;
      end
   end

   // error and loop state
   logic signed [EW-1:0]        err_ff;
   logic signed [SUM_WIDTH-1:0] sum_term_ff;
   logic signed [DW-1:0]        diff_term_ff;
   bphp_ctl_type                err_ctl_ff;

   bphp_loop #(
      .ERROR_FRAC_BITS (ERROR_FRAC_BITS),
      .SUM_WIDTH       (SUM_WIDTH)
   ) u_loop (
      .clock           (clock),
      .reset           (reset),
      .load            (free_err),
      .step            (free_err && in_valid_ff),
      .temperature     (temp_ff),
      .set_point       (set_point_ff),
      .heater_enable   (heater_enable_ff),
      .over_temp_limit (over_temp_ff),
      .err_ff          (err_ff),
      .sum_term_ff     (sum_term_ff),
      .diff_term_ff    (diff_term_ff),
      .ctl_ff          (err_ctl_ff)
   );

   // PID products; wide enough that the sum never wraps
   logic signed [NW-1:0] kp_x, ki_x, kd_x, err_x, sum_x, diff_x, pid_in;
   logic signed [NW-1:0] pid_ff;
   bphp_ctl_type         pid_ctl_ff;

   assign kp_x   = NW'(prop_gain_ff);
   assign ki_x   = NW'(int_gain_ff);
   assign kd_x   = NW'(deriv_gain_ff);
   assign err_x  = NW'(err_ff);
   assign sum_x  = NW'(sum_term_ff);
   assign diff_x = NW'(diff_term_ff);
   assign pid_in = kp_x * err_x + ki_x * sum_x + kd_x * diff_x;

   always_ff @(posedge clock) begin
      if (free_pid) begin
         pid_ff     <= pid_in;
         pid_ctl_ff <= err_ctl_ff;
      end
   end

   // duty clamp into the output register
   logic [DUTY_W-1:0] duty_in;
   logic [DUTY_W-1:0] rsp_duty_ff;
   logic              rsp_settled_ff;

   bphp_duty #(
      .ERROR_FRAC_BITS (ERROR_FRAC_BITS),
      .N_WIDTH         (NW)
   ) u_duty (
      .pid_sum    (pid_ff),
      .ctl        (pid_ctl_ff),
      .duty_limit (duty_limit_ff),
      .duty       (duty_in)
   );

   always_ff @(posedge clock) begin
      if (free_rsp) begin
         rsp_duty_ff    <= duty_in;
         rsp_settled_ff <= pid_ctl_ff.settled;
      end
   end

   assign rsp_duty    = rsp_duty_ff;
   assign rsp_settled = rsp_settled_ff;

endmodule

### src/bphp_chk.sv
// Port-level checks for banded_pid_heater_pwm, attached by the bind at the end.
// Depends on bphp_pkg; shadows the enable and duty limit registers from csr writes.
module bphp_chk import bphp_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [TEMP_W-1:0]      req_temperature,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [DUTY_W-1:0]      rsp_duty,
   input logic                   rsp_settled,
   input logic                   csr_write,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic              enable_ff;
   logic [DUTY_W-1:0] limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= EN_RST;
         limit_ff  <= LIM_RST;
      end else if (csr_write) begin
         if (csr_index == CSR_HEATER_ENABLE) enable_ff <= csr_wdata[0];
         if (csr_index == CSR_DUTY_LIMIT)    limit_ff  <= csr_wdata[DUTY_W-1:0];
      end
   end

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_duty) && $stable(rsp_settled))
      else $error("result word changed under stall");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty <= limit_ff)
      else $error("duty above limit");

   a_disabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !enable_ff |-> rsp_duty == '0)
      else $error("duty nonzero with heater disabled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind banded_pid_heater_pwm bphp_chk u_bphp_chk (.*);
